FILE: rtl/facl_pkg.sv
package facl_pkg;

	localparam int DEF_NUM_FRAMES  = 64;
	localparam int DEF_VALUE_BYTES = 8;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 6;
	localparam int SEG_W  = 4;
	localparam int KEY_W  = 16;
	localparam int TIME_W = 64;

	localparam int IN_DATA_W  = 224;
	localparam int OUT_DATA_W = 160;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_UPDATE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ACCESS,
		ST_SCAN,
		ST_DONE
	} state_t;

	// request payload, last field in the lowest bits
	typedef struct packed {
		logic [3:0]        pad;
		logic [TIME_W-1:0] now_time;
		logic [63:0]       record_value;
		logic [TIME_W-1:0] record_stamp;
		logic [KEY_W-1:0]  record_key;
		logic              insert_dirty;
		logic              new_segment;
		logic [SEG_W-1:0]  segment_id;
		logic [IDX_W-1:0]  frame_index;
	} in_data_t;

	typedef struct packed {
		logic [3:0]        pad;
		logic [SEG_W-1:0]  evicted_segment;
		logic              evicted;
		logic [63:0]       out_value;
		logic [TIME_W-1:0] out_stamp;
		logic [KEY_W-1:0]  out_key;
		logic [IDX_W-1:0]  frame_used;
		logic              status;
	} out_data_t;

	// per-frame marks scanned for replacement
	typedef struct packed {
		logic              dirty;
		logic [TIME_W-1:0] last_use;
		logic [SEG_W-1:0]  owner;
	} meta_t;

endpackage

FILE: rtl/frame_allocator_clean_lru_unit.sv
// Frame allocator with clean-page LRU replacement. One request on the slave side gives
// exactly one result on the master side. Records and per-frame marks live in two
// single-port-read memories; frames that were never used are handed out in order from a
// fill count, so no clearing pass follows reset. An insert into a never-used frame, a
// full report and any request on an invalid frame or unused operation go from decode
// straight to done; a read or update first reads the memories, and an update then writes
// the record back. Once every frame is in use, an insert without new_segment scans the
// mark memory one frame a cycle through its read port. The result register lets
// a new request be accepted while the previous result still waits to be taken.
module frame_allocator_clean_lru_unit #(
	parameter int NUM_FRAMES  = facl_pkg::DEF_NUM_FRAMES,
	parameter int VALUE_BYTES = facl_pkg::DEF_VALUE_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// frame_index, segment_id, new_segment, insert_dirty, record_key, record_stamp,
	// record_value, now_time, zero fill
	input  logic [facl_pkg::IN_DATA_W-1:0] s_tdata,
	// operation
	input  logic [facl_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status, frame_used, out_key, out_stamp, out_value, evicted, evicted_segment, zero fill
	output logic [facl_pkg::OUT_DATA_W-1:0] m_tdata
);
	import facl_pkg::*;

	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
	localparam int VAL_W   = 8 * VALUE_BYTES;
	localparam int REC_W   = KEY_W + TIME_W + VAL_W;
	localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam logic [FRAME_W-1:0] LAST_IDX = FRAME_W'(NUM_FRAMES - 1);
	localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(NUM_FRAMES);

	state_t              state_q, state_d;
	in_data_t            req_q;
	op_t                 op_q;
	logic [CNT_W-1:0]    fill_q;
	logic [FRAME_W-1:0]  scan_q;
	logic                found_q;
	logic [FRAME_W-1:0]  best_idx_q;
	logic [TIME_W-1:0]   best_lu_q;
	logic [SEG_W-1:0]    best_owner_q;
	out_data_t           res_q, res_d;
	out_data_t           out_q;
	logic                out_valid_q;

	logic                mem_we;
	logic [FRAME_W-1:0]  mem_waddr;
	logic [FRAME_W-1:0]  mem_raddr;
	meta_t               mem_wmeta;
	logic [REC_W-1:0]    mem_wrec;
	meta_t               rd_meta;
	logic [REC_W-1:0]    rd_rec;

	logic                fill_inc;
	logic                res_ld;
	logic                scan_start;
	logic                scan_next;
	logic                idx_ok;
	logic [FRAME_W-1:0]  idx_addr;
	logic                take;
	logic                fin_found;
	logic [FRAME_W-1:0]  fin_idx;
	logic [SEG_W-1:0]    fin_owner;
	logic                out_free;

	facl_store #(
		.NUM_FRAMES (NUM_FRAMES),
		.VALUE_BYTES(VALUE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wmeta(mem_wmeta),
		.wrec (mem_wrec),
		.raddr(mem_raddr),
		.rmeta(rd_meta),
		.rrec (rd_rec)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign out_free = !out_valid_q || m_tready;

	assign idx_ok   = CMP_W'(req_q.frame_index) < CMP_W'(fill_q);
	assign idx_addr = FRAME_W'(req_q.frame_index);

	// oldest clean frame so far, including the one whose marks arrive this cycle
	assign take      = !rd_meta.dirty && (!found_q || (rd_meta.last_use < best_lu_q));
	assign fin_found = found_q || take;
	assign fin_idx   = take ? scan_q : best_idx_q;
	assign fin_owner = take ? rd_meta.owner : best_owner_q;

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = fill_q[FRAME_W-1:0];
		mem_raddr  = '0;
		mem_wmeta  = '{dirty: req_q.insert_dirty, last_use: req_q.now_time,
			owner: req_q.segment_id};
		mem_wrec   = {req_q.record_key, req_q.record_stamp, req_q.record_value[VAL_W-1:0]};
		fill_inc   = 1'b0;
		res_ld     = 1'b0;
		res_d      = '0;
		scan_start = 1'b0;
		scan_next  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				res_ld           = 1'b1;
				res_d.frame_used = req_q.frame_index;
				state_d          = ST_DONE;
				case (op_q)
					OP_INSERT: begin
						if (fill_q != FULL_CNT) begin
							mem_we           = 1'b1;
							fill_inc         = 1'b1;
							res_d.frame_used = IDX_W'(fill_q);
						end else if (req_q.new_segment) begin
							res_d.frame_used = '0;
							res_d.status     = 1'b1;
						end else begin
							// every frame in use: sweep the marks for a victim
							res_ld     = 1'b0;
							mem_raddr  = '0;
							scan_start = 1'b1;
							state_d    = ST_SCAN;
						end
					end
					OP_UPDATE, OP_READ: begin
						if (idx_ok) begin
							res_ld    = 1'b0;
							mem_raddr = idx_addr;
							state_d   = ST_ACCESS;
						end
					end
					default: ;
				endcase
			end
			ST_ACCESS: begin
				res_ld           = 1'b1;
				res_d.frame_used = req_q.frame_index;
				state_d          = ST_DONE;
				if (op_q == OP_UPDATE) begin
					// keep owner and key, restamp and mark dirty
					mem_we    = 1'b1;
					mem_waddr = idx_addr;
					mem_wmeta = '{dirty: 1'b1, last_use: req_q.now_time,
						owner: rd_meta.owner};
					mem_wrec  = {rd_rec[REC_W-1 -: KEY_W], req_q.now_time,
						req_q.record_value[VAL_W-1:0]};
				end else begin
					res_d.out_key   = rd_rec[REC_W-1 -: KEY_W];
					res_d.out_stamp = rd_rec[VAL_W +: TIME_W];
					res_d.out_value = 64'(rd_rec[VAL_W-1:0]);
				end
			end
			ST_SCAN: begin
				if (scan_q == LAST_IDX) begin
					res_ld  = 1'b1;
					state_d = ST_DONE;
					if (fin_found) begin
						mem_we                = 1'b1;
						mem_waddr             = fin_idx;
						res_d.frame_used      = IDX_W'(fin_idx);
						res_d.evicted         = 1'b1;
						res_d.evicted_segment = fin_owner;
					end else begin
						res_d.status = 1'b1;
					end
				end else begin
					mem_raddr = scan_q + 1'b1;
					scan_next = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			scan_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
			if (scan_start) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (scan_next) begin
				scan_q  <= scan_q + 1'b1;
				found_q <= fin_found;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= in_data_t'(s_tdata);
			op_q  <= op_t'(s_tuser);
		end
		if (scan_next) begin
			best_idx_q   <= fin_idx;
			best_lu_q    <= take ? rd_meta.last_use : best_lu_q;
			best_owner_q <= fin_owner;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond frame count");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + 1'b1)
		else $error("fill count moved by other than one");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_DECODE || state_q == ST_ACCESS || state_q == ST_SCAN))
		else $error("store written outside a working state");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_DECODE)
		else $error("accepted request not decoded");

endmodule

FILE: rtl/facl_store.sv
module facl_store #(
	parameter int NUM_FRAMES  = facl_pkg::DEF_NUM_FRAMES,
	parameter int VALUE_BYTES = facl_pkg::DEF_VALUE_BYTES,
	localparam int FRAME_W    = $clog2(NUM_FRAMES),
	localparam int REC_W      = facl_pkg::KEY_W + facl_pkg::TIME_W + 8 * VALUE_BYTES
) (
	input  logic               clk,
	input  logic               we,
	input  logic [FRAME_W-1:0] waddr,
	input  facl_pkg::meta_t    wmeta,
	input  logic [REC_W-1:0]   wrec,
	input  logic [FRAME_W-1:0] raddr,
	output facl_pkg::meta_t    rmeta,
	output logic [REC_W-1:0]   rrec
);
	import facl_pkg::*;

	meta_t            meta_mem [NUM_FRAMES];
	logic [REC_W-1:0] rec_mem  [NUM_FRAMES];

	always_ff @(posedge clk) begin
		if (we) begin
			meta_mem[waddr] <= wmeta;
			rec_mem[waddr]  <= wrec;
		end
	end

	always_ff @(posedge clk) begin
		rmeta <= meta_mem[raddr];
		rrec  <= rec_mem[raddr];
	end

endmodule
